### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk_i, off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, written as antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tpid_pkg.sv
// Package for the time-of-flight particle identification block: types, constants.
package tpid_pkg;

  localparam int NHYP = 4;

  typedef enum logic [2:0] {
    SP_NONE     = 3'd0,
    SP_DEUTERON = 3'd1,
    SP_PROTON   = 3'd2,
    SP_PION     = 3'd3,
    SP_KAON     = 3'd4
  } species_e;

  localparam species_e LANE_CODE [NHYP] = '{SP_DEUTERON, SP_PROTON, SP_PION, SP_KAON};

  // squared masses, masses in 1/4096 GeV
  localparam int MSQ_W = 26;
  localparam logic [MSQ_W-1:0] MASS_SQ [NHYP] = '{
    26'd59013124, 26'd14768649, 26'd327184, 26'd4088484
  };

  // denominator per unit momentum: 299792 * 256
  localparam int DEN_K_W = 27;
  localparam logic [DEN_K_W-1:0] DEN_K = 27'd76746752;
  localparam int LSC_W = 14;
  localparam logic [LSC_W-1:0] LIGHT_SCALE = 14'd10000;

  localparam int RAD_W  = 49;   // (p^2 + m^2) << 16
  localparam int SQ_N   = 25;   // root bits
  localparam int DN_W   = 43;   // p * DEN_K
  localparam int PE_W   = 41;   // path * e8
  localparam int NUM_W  = 56;   // path * e8 * 10000 + den/2
  localparam int DV_N   = 25;   // quotient bits
  localparam int DIV_CW = 68;   // compare width of shifted divisor
  localparam int DT_W   = 26;

  // pipeline stage positions
  localparam int ST_SQ0  = 1;
  localparam int ST_MUL1 = ST_SQ0 + SQ_N + 1;
  localparam int ST_MUL2 = ST_MUL1 + 1;
  localparam int ST_DVE  = ST_MUL2 + DV_N;
  localparam int ST_DT   = ST_DVE + 1;
  localparam int ST_PAIR = ST_DT + 1;
  localparam int ST_FIN  = ST_PAIR + 1;
  localparam int NSTG    = ST_FIN + 1;

  typedef struct packed {
    logic [15:0]        path;
    logic signed [16:0] ds;   // start - hit
    logic               pz;   // zero momentum
  } ctl_t;

  typedef struct packed {
    logic [15:0] diff;
    species_e    sp;
  } res_t;

endpackage

### design/tof_particle_id_select.sv
// Top level: pipelined time-of-flight particle identification.
// Usage:
//   Slave stream s_axis carries one track per item (momentum, path length,
//   hit time, event start). Master stream m_axis returns one result per item:
//   the species code of the best mass hypothesis and its time difference.
//   Throughput: one item per cycle while the output does not stall. Path from
//   acceptance to the result on m_axis: input register, 55 pipeline stages
//   behind it, the final stage and the output register.
//   The depth is set by the bit-per-stage square root (25 stages) and the
//   bit-per-stage divider (25 stages) that each of the four hypothesis lanes
//   runs in parallel.
//   A skid register behind the output register absorbs one item when the
//   receiver stalls; the pipeline then freezes as a whole, s_axis_tready goes
//   low as soon as the skid register is full, and nothing is lost or repeated.
//   Reset clears all valid bits, including those of the output and skid
//   registers; no item is in flight afterwards.
//   Zero momentum gives species none with a time difference of zero.
module tof_particle_id_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // momentum, path_length, hit_time, event_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // species, best_time_diff, zero pad
);
  import tpid_pkg::*;
  `include "assert_macros.svh"

  logic              en;
  logic [NSTG-1:0]   vld_q;
  ctl_t              ctl_q [ST_FIN];
  logic [15:0]       p0_q;
  logic [31:0]       psq0_q;
  logic [DN_W-1:0]   dn_q [ST_SQ0:ST_DVE-1];
  logic [DT_W-1:0]   dt_q [NHYP];
  logic [DT_W-1:0]   pm_q [2];
  species_e          pc_q [2];
  res_t              fin_d, fin_q;
  res_t              out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              take;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // input stage and control carried along the pipe
  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q         <= s_axis_tdata[15:0];
      psq0_q       <= 32'(s_axis_tdata[15:0]) * 32'(s_axis_tdata[15:0]);
      ctl_q[0].path <= s_axis_tdata[31:16];
      ctl_q[0].ds   <= $signed({s_axis_tdata[63], s_axis_tdata[63:48]})
                     - $signed({s_axis_tdata[47], s_axis_tdata[47:32]});
      ctl_q[0].pz   <= (s_axis_tdata[15:0] == 16'd0);
      for (int k = 1; k < ST_FIN; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
      dn_q[ST_SQ0] <= DN_W'(p0_q) * DN_W'(DEN_K);
      for (int k = ST_SQ0 + 1; k < ST_DVE; k++) begin
        dn_q[k] <= dn_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < NHYP; l++) begin : g_lane
    logic [RAD_W-1:0] srem_q  [SQ_N+1];
    logic [SQ_N-1:0]  sroot_q [SQ_N+1];
    logic [PE_W-1:0]  pe_q;
    logic [NUM_W-1:0] drem_q  [DV_N+1];
    logic [DV_N-1:0]  quo_q   [DV_N+1];
    logic signed [26:0] dsum;
    logic signed [26:0] dabs;

    always_ff @(posedge clk_i) begin
      if (en) begin
        srem_q[0]  <= {33'(psq0_q) + 33'(MASS_SQ[l]), 16'b0};
        sroot_q[0] <= '0;
      end
    end

    for (genvar j = 1; j <= SQ_N; j++) begin : g_sq
      localparam int B = SQ_N - j;
      logic [RAD_W+1:0] trial;
      assign trial = ({(RAD_W+2-SQ_N)'(0), sroot_q[j-1]} << (B + 1))
                   + ((RAD_W+2)'(1) << (2 * B));
      always_ff @(posedge clk_i) begin
        if (en) begin
          if ({2'b0, srem_q[j-1]} >= trial) begin
            srem_q[j]  <= srem_q[j-1] - trial[RAD_W-1:0];
            sroot_q[j] <= sroot_q[j-1] | (SQ_N'(1) << B);
          end else begin
            srem_q[j]  <= srem_q[j-1];
            sroot_q[j] <= sroot_q[j-1];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pe_q      <= PE_W'(ctl_q[ST_MUL1-1].path) * PE_W'(sroot_q[SQ_N]);
        drem_q[0] <= NUM_W'(pe_q) * NUM_W'(LIGHT_SCALE) + NUM_W'(dn_q[ST_MUL2-1] >> 1);
        quo_q[0]  <= '0;
      end
    end

    for (genvar j = 1; j <= DV_N; j++) begin : g_dv
      localparam int B = DV_N - j;
      logic [DIV_CW-1:0] dv;
      assign dv = {(DIV_CW-DN_W)'(0), dn_q[ST_MUL2+j-1]} << B;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if ({(DIV_CW-NUM_W)'(0), drem_q[j-1]} >= dv) begin
            drem_q[j] <= drem_q[j-1] - dv[NUM_W-1:0];
            quo_q[j]  <= quo_q[j-1] | (DV_N'(1) << B);
          end else begin
            drem_q[j] <= drem_q[j-1];
            quo_q[j]  <= quo_q[j-1];
          end
        end
      end
    end

    assign dsum = {{10{ctl_q[ST_DT-1].ds[16]}}, ctl_q[ST_DT-1].ds}
                + $signed({2'b0, quo_q[DV_N]});
    assign dabs = dsum[26] ? -dsum : dsum;

    always_ff @(posedge clk_i) begin
      if (en) begin
        dt_q[l] <= dabs[DT_W-1:0];
      end
    end
  end

  // min tree, ties keep the lower lane
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int h = 0; h < 2; h++) begin
        if (dt_q[2*h+1] < dt_q[2*h]) begin
          pm_q[h] <= dt_q[2*h+1];
          pc_q[h] <= LANE_CODE[2*h+1];
        end else begin
          pm_q[h] <= dt_q[2*h];
          pc_q[h] <= LANE_CODE[2*h];
        end
      end
      fin_q <= fin_d;
    end
  end

  always_comb begin
    logic [DT_W-1:0] m;
    species_e        c;
    if (pm_q[1] < pm_q[0]) begin
      m = pm_q[1];
      c = pc_q[1];
    end else begin
      m = pm_q[0];
      c = pc_q[0];
    end
    if (ctl_q[ST_FIN-1].pz) begin
      fin_d.sp   = SP_NONE;
      fin_d.diff = '0;
    end else begin
      fin_d.sp   = c;
      fin_d.diff = (|m[DT_W-1:16]) ? 16'hFFFF : m[15:0];
    end
  end

  // output register with skid stage
  assign take = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= vld_q[ST_FIN];
      end
    end else if (vld_q[ST_FIN] && en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : fin_q;
    end else if (en) begin
      skid_q <= fin_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.diff, out_q.sp};

  `ASSERT_CLK(a_skid_needs_out, skid_valid_q |-> out_valid_q,
    "skid register full while output register empty")
  `ASSERT_NEXT(a_stall_holds_out, out_valid_q && !m_axis_tready, out_valid_q,
    "stalled result dropped")
  `ASSERT_NEXT(a_freeze_pipe, skid_valid_q, $stable(vld_q),
    "pipeline moved while skid register full")
  `ASSERT_CLK(a_none_zero_diff, out_valid_q && out_q.sp == SP_NONE |-> out_q.diff == 16'd0,
    "species none with nonzero time difference")

endmodule
